// File: hw/rtl/htb_pkg.sv
// shared types and constants for the huffman tree build and decode block
`timescale 1ns / 1ps

package htb_pkg;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  symbol;
        logic [31:0] weight;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  decoded_symbol;
        logic [31:0] repeat_res;
        logic        status;
        logic        last;
    } t_out_item;

    typedef logic [31:0] t_cfg_word;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_BUILD = 2'd1;
    localparam logic [1:0] ACT_DATA  = 2'd2;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_EMPTY = 1'b1;

    // free list entry carries the node and the fields the scan and merge need
    typedef struct packed {
        logic [8:0]  node;
        logic [31:0] weight;
        logic [7:0]  level;
        logic [7:0]  symbol;
    } t_fl_entry;

    typedef struct packed {
        logic [8:0] child;
        logic       leaf;
        logic [7:0] symbol;
    } t_child;

    typedef struct packed {
        t_child one;
        t_child zero;
    } t_node_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL_RD,
        S_FILL_EV,
        S_CHECK,
        S_BUILD_RES,
        S_SCAN_RD,
        S_SCAN_EV,
        S_MERGE_A,
        S_MERGE_B,
        S_FINISH,
        S_WALK_RD,
        S_WALK_EV
    } t_state;

    typedef struct packed {
        logic load;
        logic fill_start;
        logic fill_rd;
        logic fill_ev;
        logic check;
        logic build_res;
        logic scan_rd;
        logic scan_ev;
        logic merge_a;
        logic merge_b;
        logic finish;
        logic walk_start;
        logic walk_rd;
        logic walk_ev;
    } t_cmd;

    typedef struct packed {
        logic fill_last;
        logic leaves_small;
        logic scan_last;
        logic merge_more;
        logic walk_ok;
        logic walk_leaf;
        logic walk_stop;
        logic out_free;
    } t_status;

endpackage

// File: hw/rtl/htb_stream_if.sv
// valid/ready channel interface
`timescale 1ns / 1ps

interface htb_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/htb_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module htb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: hw/rtl/htb_ctrl.sv
// controller state machine for build and decode
`timescale 1ns / 1ps

module htb_ctrl
    import htb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_action,
    output logic       o_in_ready,
    input  t_status    i_status,
    output t_cmd       o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_in_action)
                        ACT_LOAD: begin
                            o_cmd.load = 1'b1;
                        end
                        ACT_BUILD: begin
                            o_cmd.fill_start = 1'b1;
                            n_state = S_FILL_RD;
                        end
                        ACT_DATA: begin
                            if (i_status.walk_ok) begin
                                o_cmd.walk_start = 1'b1;
                                n_state = S_WALK_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FILL_RD: begin
                o_cmd.fill_rd = 1'b1;
                n_state = S_FILL_EV;
            end
            S_FILL_EV: begin
                o_cmd.fill_ev = 1'b1;
                n_state = i_status.fill_last ? S_CHECK : S_FILL_RD;
            end
            S_CHECK: begin
                if (i_status.leaves_small) begin
                    n_state = S_BUILD_RES;
                end else begin
                    o_cmd.check = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_BUILD_RES: begin
                if (i_status.out_free) begin
                    o_cmd.build_res = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                o_cmd.scan_ev = 1'b1;
                n_state = i_status.scan_last ? S_MERGE_A : S_SCAN_RD;
            end
            S_MERGE_A: begin
                o_cmd.merge_a = 1'b1;
                n_state = S_MERGE_B;
            end
            S_MERGE_B: begin
                o_cmd.merge_b = 1'b1;
                n_state = i_status.merge_more ? S_SCAN_RD : S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            S_WALK_RD: begin
                o_cmd.walk_rd = 1'b1;
                n_state = S_WALK_EV;
            end
            S_WALK_EV: begin
                if (!i_status.walk_leaf || i_status.out_free) begin
                    o_cmd.walk_ev = 1'b1;
                    n_state = i_status.walk_stop ? S_IDLE : S_WALK_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// File: hw/rtl/htb_dp.sv
// datapath: frequency store, free list, node memory, decode walk, result register
`timescale 1ns / 1ps

module htb_dp
    import htb_pkg::*;
#(
    parameter int SYMBOL_COUNT = 256,
    parameter int NODE_COUNT   = 511
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in,
    input  logic      i_cfg_valid,
    input  t_cfg_word i_cfg_data,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);
    localparam int HALF = (NODE_COUNT + 1) / 2;
    localparam int CAP  = (HALF < SYMBOL_COUNT) ? HALF : SYMBOL_COUNT;
    localparam int SA   = $clog2(SYMBOL_COUNT);
    localparam int FA   = $clog2(CAP);
    localparam int NA   = $clog2(NODE_COUNT);
    localparam int FLW  = $bits(t_fl_entry);
    localparam int NDW  = $bits(t_node_entry);

    // configuration and control registers
    logic [31:0]       r_total;
    logic              r_tree_ready;
    logic [SYMBOL_COUNT-1:0] r_fvld;
    logic              r_fvld_q;
    logic [8:0]        r_sidx;
    logic [8:0]        r_leaves;
    logic [7:0]        r_sym0;
    logic [8:0]        r_last;
    logic [8:0]        r_j;
    logic [9:0]        r_nn;
    logic [8:0]        r_ai;
    logic [8:0]        r_bi;
    t_fl_entry         r_ea;
    t_fl_entry         r_eb;
    t_fl_entry         r_elast;
    t_fl_entry         r_new;
    logic [8:0]        r_root;
    logic [8:0]        r_cur;
    logic [7:0]        r_byte;
    logic [2:0]        r_bit;
    logic [31:0]       r_count;
    logic              r_out_valid;
    t_out_item         r_out;

    // memory ports
    logic [31:0]       freq_rd;
    logic [FLW-1:0]    fl_rd;
    logic [NDW-1:0]    nd_rd;
    logic              fl_we;
    logic [FA-1:0]     fl_waddr;
    t_fl_entry         fl_wdata;
    logic [FA-1:0]     fl_raddr;
    logic              load_ok;
    logic              out_free;
    logic              out_load;
    t_out_item         out_next;
    t_fl_entry         e_rd;
    t_node_entry       nd;
    t_child            ch;
    t_fl_entry         e_new;
    t_node_entry       nd_new;
    logic              fill_take;
    logic [31:0]       count_inc;

    assign load_ok   = i_cmd.load && ({1'b0, i_in.symbol} < 9'(SYMBOL_COUNT));
    assign out_free  = !r_out_valid || i_out_ready;
    assign e_rd      = t_fl_entry'(fl_rd);
    assign nd        = t_node_entry'(nd_rd);
    assign ch        = r_byte[7] ? nd.one : nd.zero;
    assign fill_take = r_fvld_q && (freq_rd != 32'd0) && (r_leaves < 9'(CAP));
    assign count_inc = r_count + 32'd1;

    htb_ram #(.WIDTH(32), .DEPTH(SYMBOL_COUNT)) u_freq (
        .i_clk     (i_clk),
        .i_wr_en   (load_ok),
        .i_wr_addr (i_in.symbol[SA-1:0]),
        .i_wr_data (i_in.weight),
        .i_rd_en   (i_cmd.fill_rd),
        .i_rd_addr (r_sidx[SA-1:0]),
        .o_rd_data (freq_rd)
    );

    htb_ram #(.WIDTH(FLW), .DEPTH(CAP)) u_free (
        .i_clk     (i_clk),
        .i_wr_en   (fl_we),
        .i_wr_addr (fl_waddr),
        .i_wr_data (fl_wdata),
        .i_rd_en   (i_cmd.scan_rd),
        .i_rd_addr (fl_raddr),
        .o_rd_data (fl_rd)
    );

    htb_ram #(.WIDTH(NDW), .DEPTH(NODE_COUNT)) u_node (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.merge_a),
        .i_wr_addr (r_nn[NA-1:0]),
        .i_wr_data (nd_new),
        .i_rd_en   (i_cmd.walk_rd),
        .i_rd_addr (r_cur[NA-1:0]),
        .o_rd_data (nd_rd)
    );

    assign fl_raddr = r_j[FA-1:0];

    always_comb begin
        e_new.node   = r_nn[8:0];
        e_new.weight = r_ea.weight + r_eb.weight;
        e_new.level  = r_ea.level + 8'd1;
        e_new.symbol = '0;
        if (r_ea.level <= r_eb.level) begin
            nd_new.zero = '{child: r_ea.node, leaf: (r_ea.level == 8'd0), symbol: r_ea.symbol};
            nd_new.one  = '{child: r_eb.node, leaf: (r_eb.level == 8'd0), symbol: r_eb.symbol};
        end else begin
            nd_new.zero = '{child: r_eb.node, leaf: (r_eb.level == 8'd0), symbol: r_eb.symbol};
            nd_new.one  = '{child: r_ea.node, leaf: (r_ea.level == 8'd0), symbol: r_ea.symbol};
        end
    end

    always_comb begin
        fl_we    = 1'b0;
        fl_waddr = r_leaves[FA-1:0];
        fl_wdata = '{node: r_leaves, weight: freq_rd, level: 8'd0,
                     symbol: r_sidx[7:0]};
        if (i_cmd.fill_ev) begin
            fl_we = fill_take;
        end else if (i_cmd.merge_a) begin
            fl_we    = 1'b1;
            fl_waddr = r_ai[FA-1:0];
            fl_wdata = e_new;
        end else if (i_cmd.merge_b) begin
            fl_we    = 1'b1;
            fl_waddr = r_bi[FA-1:0];
            fl_wdata = (r_ai == r_last) ? r_new : r_elast;
        end
    end

    always_comb begin
        out_load = 1'b0;
        out_next = '{decoded_symbol: ch.symbol, repeat_res: 32'd1, status: ST_OK,
                     last: (count_inc == r_total)};
        if (i_cmd.build_res) begin
            out_load = 1'b1;
            if (r_leaves == 9'd0) begin
                out_next = '{decoded_symbol: 8'd0, repeat_res: 32'd0, status: ST_EMPTY,
                             last: 1'b1};
            end else begin
                out_next = '{decoded_symbol: r_sym0, repeat_res: r_total, status: ST_OK,
                             last: 1'b1};
            end
        end else if (i_cmd.walk_ev && ch.leaf) begin
            out_load = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total      <= '0;
            r_tree_ready <= 1'b0;
            r_fvld       <= '0;
            r_count      <= '0;
            r_cur        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_total <= i_cfg_data;
            end
            if (load_ok) begin
                r_fvld[i_in.symbol[SA-1:0]] <= 1'b1;
                r_tree_ready <= 1'b0;
            end
            if (i_cmd.fill_start) begin
                r_tree_ready <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_tree_ready <= 1'b1;
                r_count      <= '0;
                r_cur        <= r_nn[8:0] - 9'd1;
            end
            if (i_cmd.walk_ev) begin
                if (ch.leaf) begin
                    r_count <= count_inc;
                    r_cur   <= r_root;
                end else begin
                    r_cur <= ch.child;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_start) begin
            r_sidx   <= '0;
            r_leaves <= '0;
        end
        if (i_cmd.fill_rd) begin
            r_fvld_q <= r_fvld[r_sidx[SA-1:0]];
        end
        if (i_cmd.fill_ev) begin
            r_sidx <= r_sidx + 9'd1;
            if (fill_take) begin
                r_leaves <= r_leaves + 9'd1;
                if (r_leaves == 9'd0) begin
                    r_sym0 <= r_sidx[7:0];
                end
            end
        end
        if (i_cmd.check) begin
            r_last <= r_leaves - 9'd1;
            r_nn   <= {1'b0, r_leaves};
            r_j    <= '0;
        end
        if (i_cmd.scan_ev) begin
            r_j <= r_j + 9'd1;
            if (r_j == r_last) begin
                r_elast <= e_rd;
            end
            if (r_j == 9'd0) begin
                r_ea <= e_rd;
                r_ai <= '0;
            end else if (r_j == 9'd1) begin
                if (r_ea.weight < e_rd.weight) begin
                    r_eb <= e_rd;
                    r_bi <= 9'd1;
                end else begin
                    r_eb <= r_ea;
                    r_bi <= r_ai;
                    r_ea <= e_rd;
                    r_ai <= 9'd1;
                end
            end else if (e_rd.weight < r_ea.weight) begin
                r_eb <= r_ea;
                r_bi <= r_ai;
                r_ea <= e_rd;
                r_ai <= r_j;
            end else if (e_rd.weight < r_eb.weight) begin
                r_eb <= e_rd;
                r_bi <= r_j;
            end
        end
        if (i_cmd.merge_a) begin
            r_new <= e_new;
        end
        if (i_cmd.merge_b) begin
            r_last <= r_last - 9'd1;
            r_nn   <= r_nn + 10'd1;
            r_j    <= '0;
        end
        if (i_cmd.finish) begin
            r_root <= r_nn[8:0] - 9'd1;
        end
        if (i_cmd.walk_start) begin
            r_byte <= i_in.data_byte;
            r_bit  <= '0;
        end
        if (i_cmd.walk_ev) begin
            r_byte <= {r_byte[6:0], 1'b0};
            r_bit  <= r_bit + 3'd1;
        end
        if (out_load) begin
            r_out <= out_next;
        end
    end

    assign o_status.fill_last    = (r_sidx == 9'(SYMBOL_COUNT - 1));
    assign o_status.leaves_small = (r_leaves < 9'd2);
    assign o_status.scan_last    = (r_j == r_last);
    assign o_status.merge_more   = (r_last > 9'd1) && ((r_nn + 10'd1) < 10'(NODE_COUNT));
    assign o_status.walk_ok      = r_tree_ready && (r_count < r_total);
    assign o_status.walk_leaf    = ch.leaf;
    assign o_status.walk_stop    = (r_bit == 3'd7) || (ch.leaf && (count_inc == r_total));
    assign o_status.out_free     = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTH
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result register overwritten");
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk_rd |-> (r_cur < 9'(NODE_COUNT)))
        else $error("walk node out of range");
    a_merge_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.merge_b |-> (r_ai != r_bi))
        else $error("merge picked one entry twice");
    a_ready_tree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_tree_ready) |-> (r_nn > 10'd2))
        else $error("tree ready without internal node");
`endif
endmodule

// File: hw/rtl/huffman_tree_build_decode.sv
// top level of the huffman tree build and decode block
//
//  channel  dir  payload                                      request accepted when
//  i_in     in   action, symbol, weight, data_byte            valid && ready
//  o_out    out  decoded_symbol, repeat_res, status, last     valid && ready
//  i_cfg    in   symbol_total                                 valid && ready
//
// a load writes one weight into the frequency store; a build reads each weight for leaf fill,
// then per merge round scans the free list (one ram read per entry), merging the lightest two
// a data byte walks msb first, a node read then a step per bit, to bit 7 or the last symbol
// synchronous active low reset; the frequency store is cleared through per-entry valid bits
// a result waits in the output register; the walk stalls while it is not taken
`timescale 1ns / 1ps

module huffman_tree_build_decode
    import htb_pkg::*;
#(
    parameter int SYMBOL_COUNT = 256,
    parameter int NODE_COUNT   = 511
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    htb_stream_if.sink   i_in,
    htb_stream_if.source o_out,
    htb_stream_if.sink   i_cfg
);
    t_cmd      cmd;
    t_status   status;
    t_in_item  in_item;
    t_out_item out_item;
    logic      in_ready;

    assign in_item     = i_in.data;
    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.data  = out_item;

    htb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (in_item.action),
        .o_in_ready  (in_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    htb_dp #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .NODE_COUNT   (NODE_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_item),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out       (out_item)
    );
endmodule
